### rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg: shared types and constants of the fit-policy block allocator
// Table geometry, status codes, fit styles, request and entry types, sequencer states and region sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package fpba_pkg;

  localparam int unsigned MaxBlocks   = 64;
  localparam int unsigned IdxW        = $clog2(MaxBlocks);
  localparam int unsigned CntW        = $clog2(MaxBlocks + 1);
  localparam int unsigned HeaderBytes = 16;
  localparam int unsigned AlignBytes  = 8;
  localparam int unsigned PageBytes   = 4096;
  localparam int unsigned AddrW       = 20;
  localparam int unsigned SizeW       = 21;
  localparam int unsigned EntryW      = AddrW + SizeW + 1;
  localparam int unsigned QDepth      = 2;

  localparam logic [SizeW-1:0] SpaceLimit = SizeW'(1 << AddrW);
  localparam logic [SizeW-1:0] RegionMax  = SizeW'(((1 << AddrW) / PageBytes) * PageBytes);
  localparam int unsigned      PageShift  = $clog2(PageBytes);
  localparam int unsigned      AlignShift = $clog2(AlignBytes);

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_SPACE    = 3'd1,
    ST_BAD_POINTER = 3'd2,
    ST_BAD_ARG     = 3'd3,
    ST_TABLE_FULL  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FIT_BEST  = 2'd0,
    FIT_WORST = 2'd1,
    FIT_FIRST = 2'd2,
    FIT_NONE  = 2'd3
  } fit_e;

  // classified request passed from front to back
  typedef struct packed {
    logic             is_free;
    logic             bad_arg;
    fit_e             fit;
    logic [SizeW-1:0] need;
    logic [AddrW-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [AddrW-1:0] start;
    logic [SizeW-1:0] total;
    logic             is_free;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIX,
    S_NB_RD,
    S_NB,
    S_MERGE,
    S_DONE
  } state_e;

  // round region size up to a page, clamp to legal range
  function automatic logic [SizeW-1:0] region_size(input logic [SizeW-1:0] v);
    logic [SizeW:0] r;
    begin
      r = ({1'b0, v} + (SizeW+1)'(PageBytes - 1)) >> PageShift << PageShift;
      if (r == '0) r = (SizeW+1)'(PageBytes);
      if (r > {1'b0, RegionMax}) r = {1'b0, RegionMax};
      region_size = r[SizeW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/fpba_ram.sv
// ----------------------------------------------------------------------------
// fpba_ram: generic single-port-write, one-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### rtl/fpba_front.sv
// ----------------------------------------------------------------------------
// fpba_front: request intake and classification
// Checks arguments, rounds the size, and queues descriptors for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [47:0]     s_axis_tdata,
  input  wire logic            s_axis_tuser,
  output logic                 req_valid_o,
  input  wire logic            req_pop_i,
  output fpba_pkg::req_t       req_o
);
  import fpba_pkg::*;

  logic [SizeW-1:0] req_bytes;
  logic [1:0]       fit_raw;
  logic [AddrW-1:0] free_addr;
  logic [SizeW:0]   rounded;
  req_t             cls;
  req_t             q_q [QDepth];
  logic [$clog2(QDepth)-1:0] wp_q, rp_q;
  logic [$clog2(QDepth+1)-1:0] cnt_q;
  logic push;

  assign req_bytes = s_axis_tdata[SizeW-1:0];
  assign fit_raw   = s_axis_tdata[SizeW+1:SizeW];
  assign free_addr = s_axis_tdata[SizeW+2+AddrW-1:SizeW+2];

  // classify
  always_comb begin
    rounded       = ({1'b0, req_bytes} + (SizeW+1)'(AlignBytes - 1)) >> AlignShift << AlignShift;
    cls.is_free   = s_axis_tuser;
    cls.bad_arg   = (req_bytes == '0) || (req_bytes > SpaceLimit) || (fit_raw == FIT_NONE);
    cls.fit       = fit_e'(fit_raw);
    cls.need      = SizeW'(rounded + (SizeW+1)'(HeaderBytes));
    cls.free_addr = free_addr;
  end

  assign s_axis_tready = (cnt_q != QDepth[$clog2(QDepth+1)-1:0]);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (cnt_q != '0);
  assign req_o         = q_q[rp_q];

  // descriptor queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (req_pop_i) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (push ? 1'b1 : 1'b0) - (req_pop_i ? 1'b1 : 1'b0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_q[wp_q] <= cls;
  end

endmodule

`default_nettype wire

### rtl/fpba_back.sv
// ----------------------------------------------------------------------------
// fpba_back: table sequencer
// Scans the block table in RAM, splits, marks, merges and reports a result.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [20:0]            cfg_wdata_i,
  input  wire logic                   req_valid_i,
  output logic                        req_pop_o,
  input  wire fpba_pkg::req_t         req_i,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [23:0]                 m_axis_tdata
);
  import fpba_pkg::*;

  state_e state_q, state_d;
  req_t   r_q;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] i_q, pick_q;
  logic            found_q, hit_q;
  entry_t          pe_q, ce_q;
  logic [SizeW-1:0] rem_q;
  logic            split_q, mrgl_q;
  logic [AddrW-1:0] addr_q;
  status_e         stat_q;
  logic            ov_q;
  logic [23:0]     od_q;
  // table written as start/total/free per entry
  logic            we;
  logic [IdxW-1:0] wa, ra;
  entry_t          wd, rd;
  logic [SizeW-1:0] rgn_q;
  logic            last;
  logic            fit_ok, better;
  logic            init_q;
  // free merge bookkeeping
  logic            lmrg;
  logic [1:0]      nrm, dist_q;
  logic [CntW-1:0] cnt_new, dst;

  fpba_ram #(.Width(EntryW), .Depth(MaxBlocks)) u_tbl (
    .clk_i, .we_i(we), .waddr_i(wa), .wdata_i(wd), .raddr_i(ra), .rdata_o(rd)
  );

  assign last   = ({1'b0, i_q} + 1'b1) >= count_q;
  assign fit_ok = rd.is_free && (rd.total >= r_q.need);
  always_comb begin
    case (r_q.fit)
      FIT_BEST:  better = rd.total < pe_q.total;
      FIT_WORST: better = rd.total > pe_q.total;
      default:   better = 1'b0;
    endcase
  end

  // left neighbour (rd in S_MERGE) and entries removed by a free
  assign lmrg    = (i_q != '0) && rd.is_free;
  assign nrm     = {1'b0, lmrg} + {1'b0, hit_q};
  assign cnt_new = count_q - CntW'(nrm);
  assign dst     = lmrg ? CntW'(i_q) : CntW'(i_q) + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:
        if (!ov_q && req_valid_i) begin
          if (!req_i.is_free && req_i.bad_arg) state_d = S_DONE;
          else                                  state_d = S_SCAN_RD;
        end
      S_SCAN_RD: state_d = S_SCAN;
      S_SCAN: begin
        if (r_q.is_free) begin
          if (!rd.is_free && (rd.start + AddrW'(HeaderBytes) == r_q.free_addr))
            state_d = S_NB_RD;
          else if (last) state_d = S_DONE;
        end else if (fit_ok && (!found_q || r_q.fit == FIT_FIRST)) begin
          if (r_q.fit == FIT_FIRST || last) state_d = S_FIX;
        end else if (last) state_d = found_q ? S_FIX : S_DONE;
      end
      S_FIX: begin
        if (!split_q) state_d = S_DONE;
        else if (count_q >= CntW'(MaxBlocks)) state_d = S_DONE;
        else state_d = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (mrgl_q) state_d = (({1'b0, i_q} + 1'b1) >= count_q) ? S_DONE : S_SHIFT_RD;
        else        state_d = (i_q == pick_q + 1'b1) ? S_DONE : S_SHIFT_RD;
      end
      S_NB_RD:    state_d = S_NB;
      S_NB:       state_d = S_MERGE;
      S_MERGE:
        state_d = ((nrm != 2'd0) && (dst < cnt_new)) ? S_SHIFT_RD : S_DONE;
      S_DONE:     if (!ov_q) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    we = 1'b0; wa = i_q; wd = rd; ra = i_q; req_pop_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        ra = '0;
        req_pop_o = !ov_q && req_valid_i;
      end
      S_SCAN: ra = i_q + 1'b1;
      S_FIX: begin
        // mark the picked entry used unless a split finds the table full; the tail piece goes in by the shift
        we = !(split_q && count_q >= CntW'(MaxBlocks)); wa = pick_q;
        wd = '{start: pe_q.start, total: split_q ? r_q.need : pe_q.total, is_free: 1'b0};
        ra = i_q - 1'b1;
      end
      S_SHIFT_RD: ra = mrgl_q ? i_q + IdxW'(dist_q) : i_q - 1'b1;
      S_SHIFT_WR: begin
        we = 1'b1; wa = i_q; wd = rd;
        if (!mrgl_q && i_q == pick_q + 1'b1) begin
          wd = '{start: pe_q.start + AddrW'(r_q.need), total: rem_q, is_free: 1'b1};
        end
      end
      S_NB_RD: ra = i_q + 1'b1;
      S_NB:    ra = i_q - 1'b1;
      S_MERGE: begin
        we = 1'b1;
        if (lmrg) begin
          wa = i_q - 1'b1;
          wd = '{start: rd.start, total: rd.total + ce_q.total, is_free: 1'b1};
        end else begin
          wa = i_q;
          wd = ce_q;
        end
      end
      default: ;
    endcase
    // rebuild entry 0 after reset or a region write
    if (init_q) begin
      we = 1'b1;
      wa = '0;
      wd = '{start: '0, total: rgn_q, is_free: 1'b1};
    end
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CntW'(1);
      ov_q    <= 1'b0;
      rgn_q   <= SizeW'(PageBytes);
    end else begin
      state_q <= state_d;
      if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
      if (state_q == S_DONE && !ov_q) ov_q <= 1'b1;
      if (cfg_we_i) begin
        count_q <= CntW'(1);
        rgn_q   <= region_size(cfg_wdata_i);
      end else if (state_q == S_FIX && split_q && count_q < CntW'(MaxBlocks)) begin
        count_q <= count_q + 1'b1;
      end else if (state_q == S_MERGE) begin
        count_q <= cnt_new;
      end
    end
  end

  // request to write entry 0 after reset or configuration, registered from cfg_we_i
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_q <= 1'b1;
    else         init_q <= cfg_we_i;
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        r_q <= req_i; i_q <= '0; found_q <= 1'b0; mrgl_q <= 1'b0;
        addr_q <= '0;
        stat_q <= (!req_i.is_free && req_i.bad_arg) ? ST_BAD_ARG :
                  (req_i.is_free ? ST_BAD_POINTER : ST_NO_SPACE);
      end
      S_SCAN: begin
        if (r_q.is_free) begin
          ce_q <= '{start: rd.start, total: rd.total, is_free: 1'b1};
          pick_q <= i_q;
        end else if (fit_ok && (!found_q || better)) begin
          found_q <= 1'b1; pick_q <= i_q; pe_q <= rd;
          rem_q <= rd.total - r_q.need;
          split_q <= (rd.total - r_q.need) > SizeW'(HeaderBytes);
        end
        if (r_q.is_free && !rd.is_free && (rd.start + AddrW'(HeaderBytes) == r_q.free_addr))
          stat_q <= ST_OK;
        else i_q <= i_q + 1'b1;
      end
      S_FIX: begin
        if (split_q && count_q >= CntW'(MaxBlocks)) stat_q <= ST_TABLE_FULL;
        else begin
          stat_q <= ST_OK;
          addr_q <= pe_q.start + AddrW'(HeaderBytes);
        end
        i_q <= IdxW'(count_q);
      end
      S_SHIFT_WR: i_q <= mrgl_q ? i_q + 1'b1 : i_q - 1'b1;
      S_NB_RD: ;
      S_NB: begin
        // right neighbour (rd) merge
        hit_q <= (({1'b0, i_q} + 1'b1) < count_q) && rd.is_free;
        if ((({1'b0, i_q} + 1'b1) < count_q) && rd.is_free)
          ce_q.total <= ce_q.total + rd.total;
      end
      S_MERGE: begin
        // close the gap left by merged entries
        i_q    <= IdxW'(dst);
        dist_q <= nrm;
        mrgl_q <= 1'b1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (state_q == S_DONE && !ov_q) od_q <= {1'b0, stat_q, addr_q};
  end
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

endmodule

`default_nettype wire

### rtl/fit_policy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_core: first/best/worst fit block allocator
// Front end classifies requests, back end sequences the block table.
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and the back end serves one at a time, one
// result transfer each; the next request starts only after that result has
// been transferred. With N the block count (at most 64), an allocate picks up
// the request, primes the table read, scans up to N entries (first fit stops
// at the first fitting block), updates the picked entry, moves entries up on
// a split with a read and a write each, and loads the result. A free scans
// until it hits, reads both neighbors and merges, moves entries down, and
// loads the result. A bad allocate argument goes straight to the result.
`default_nettype none

module fit_policy_block_allocator_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [20:0] cfg_wdata_i,   // region_bytes
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // request_bytes, fit_style, free_address
  input  wire logic        s_axis_tuser,  // mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // address, status
);
  import fpba_pkg::*;

  req_t req;
  logic req_valid, req_pop;

  fpba_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .req_valid_o(req_valid), .req_pop_i(req_pop), .req_o(req)
  );

  fpba_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .req_valid_i(req_valid), .req_pop_o(req_pop),
    .req_i(req), .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

`default_nettype wire

### rtl/fpba_checker.sv
// ----------------------------------------------------------------------------
// fpba_checker: port-level checks of the allocator
// Watches the output channel and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module fpba_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");

  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[22:20] <= 3'd4)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[22:20] != 3'd0 |-> m_axis_tdata[19:0] == '0)
    else $error("failed request carries an address");

endmodule

bind fit_policy_block_allocator_core fpba_checker u_chk (.*);

`default_nettype wire
